/* design/base64_stream_decoder_defines.svh */
// Assertion macros for the base64 stream decoder checker.
`ifndef BASE64_STREAM_DECODER_DEFINES_SVH
`define BASE64_STREAM_DECODER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define B64SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define B64SD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/b64sd_pkg.sv */
// Types, constants and decode functions for the base64 stream decoder.
package b64sd_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgIdxLimit = 2'd0;
  localparam logic [1:0] CfgIdxPaste = 2'd1;

  localparam logic [15:0] LimitReset = 16'd2047;

  // Character codes
  localparam logic [7:0] ChPad   = 8'h3d;  // '='
  localparam logic [7:0] ChPlus  = 8'h2b;  // '+'
  localparam logic [7:0] ChSlash = 8'h2f;  // '/'
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5a;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7a;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7f;

  // Offsets that map each alphabet range onto its sextet value
  localparam logic [7:0] OffsUpper = 8'd65;  // 'A' -> 0
  localparam logic [7:0] OffsLower = 8'd71;  // 'a' -> 26
  localparam logic [7:0] OffsDigit = 8'd4;   // '0' -> 52 (added)
  localparam logic [5:0] SextPlus  = 6'd62;
  localparam logic [5:0] SextSlash = 6'd63;

  // Decoder state carried from character to character
  typedef struct packed {
    logic [1:0]  phase;
    logic [5:0]  held;
    logic        pad_seen;
    logic [15:0] count;
  } state_t;

  // One result item
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        byte_valid;
    logic        message_end;
    logic [15:0] bytes_so_far;
  } result_t;

  // Sextet lookup: bit 6 set when the character is in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      t = ch - OffsUpper;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      t = ch - OffsLower;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      t = ch + OffsDigit;
      r = {1'b1, t[5:0]};
    end else if (ch == ChPlus) begin
      r = {1'b1, SextPlus};
    end else if (ch == ChSlash) begin
      r = {1'b1, SextSlash};
    end
    return r;
  endfunction

  // Clipboard-safe byte: tab to space, LF to CR, other controls, DEL and high bytes to space
  function automatic logic [7:0] sanitize(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == ChTab) r = ChSpace;
    else if (b == ChLf) r = ChCr;
    else if (b < ChSpace || b >= ChDel) r = ChSpace;
    return r;
  endfunction

endpackage

/* design/b64sd_core.sv */
// Per-character decode step: sextet lookup, byte assembly, limit and sanitizing.
module b64sd_core import b64sd_pkg::*; (
  input  state_t      st_i,
  input  logic [7:0]  in_char_i,
  input  logic        last_i,
  input  logic [15:0] limit_i,
  input  logic        paste_i,
  output state_t      st_o,
  output result_t     res_o,
  output logic        emit_o
);

  logic [6:0]  sext;
  logic [5:0]  v;
  logic        take;
  logic        have;
  logic [7:0]  raw;
  logic        give;
  logic [15:0] count_n;

  assign sext = sextet_of(in_char_i);
  assign v    = sext[5:0];
  // An alphabet character before any pad advances the quad
  assign take = !st_i.pad_seen && (in_char_i != ChPad) && sext[6];

  // Byte assembly from the held sextet and the new one
  always_comb begin
    have = 1'b0;
    raw  = 8'd0;
    unique case (st_i.phase)
      2'd0: begin
        have = 1'b0;
      end
      2'd1: begin
        have = take;
        raw  = {st_i.held, v[5:4]};
      end
      2'd2: begin
        have = take;
        raw  = {st_i.held[3:0], v[5:2]};
      end
      2'd3: begin
        have = take;
        raw  = {st_i.held[1:0], v};
      end
      default: begin
        have = 1'b0;
      end
    endcase
  end

  // Output limit and count
  assign give    = have && (st_i.count < limit_i);
  assign count_n = give ? st_i.count + 16'd1 : st_i.count;

  // Result item
  always_comb begin
    res_o.byte_out     = give ? (paste_i ? sanitize(raw) : raw) : 8'd0;
    res_o.byte_valid   = give;
    res_o.message_end  = last_i;
    res_o.bytes_so_far = count_n;
  end
  assign emit_o = give || last_i;

  // Next state; end of message clears everything
  always_comb begin
    st_o = st_i;
    if (last_i) begin
      st_o = '0;
    end else begin
      st_o.count = count_n;
      if (!st_i.pad_seen && in_char_i == ChPad) st_o.pad_seen = 1'b1;
      if (take) begin
        st_o.held  = v;
        st_o.phase = st_i.phase + 2'd1;
      end
    end
  end

endmodule

/* design/base64_stream_decoder.sv */
// Base64 stream decoder top level: input register, decode step, result register.
// Takes one base64 character per cycle while the result side is not stalled and
// gives at most one result per character: a decoded byte, an end-of-message
// marker, or both. A character is held in the input register, decoded against
// the decoder state (quad phase, held sextet, pad flag, byte count) and written
// to the result register, so a result is offered once its character has moved
// from the input register through the decode step into the result register; a new
// character is taken as the last one is decoded. Characters that give no result
// leave nothing on the output. The input side stays ready while a result
// waits, as long as the result is taken in the same cycle the next one is
// produced. Configuration writes take effect on the next character.
module base64_stream_decoder import b64sd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // last_char
  // Results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [23:8] bytes_so_far
  output logic        m_axis_tuser,   // byte_valid
  output logic        m_axis_tlast    // message_end
);

  logic        in_valid_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;
  state_t      st_q, st_d;
  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        emit;
  logic        advance;
  logic [15:0] limit_q;
  logic        paste_q;

  // The input register moves on when the result register is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  b64sd_core u_core (
    .st_i      (st_q),
    .in_char_i (in_char_q),
    .last_i    (in_last_q),
    .limit_i   (limit_q),
    .paste_i   (paste_q),
    .st_o      (st_d),
    .res_o     (res_d),
    .emit_o    (emit)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
      paste_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxLimit: limit_q <= cfg_data_i;
        CfgIdxPaste: paste_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control: input valid, decoder state, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_last_q   <= 1'b0;
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
        if (s_axis_tvalid) in_last_q <= s_axis_tlast;
      end
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= emit;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_char_q <= s_axis_tdata;
    if (advance && emit) out_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.bytes_so_far, out_q.byte_out};
  assign m_axis_tuser  = out_q.byte_valid;
  assign m_axis_tlast  = out_q.message_end;

endmodule

/* design/b64sd_checker.sv */
// Port-level checker for the base64 stream decoder, bound to the top level.
`include "base64_stream_decoder_defines.svh"

module b64sd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result transaction holds its payload
  `B64SD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // A result without a byte exists only to mark the end of a message
  `B64SD_ASSERT(a_empty_is_end, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "empty result without end flag")

  // A result without a byte carries a zero byte; a result with a byte carries a nonzero count
  `B64SD_ASSERT(a_byte_fields, m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[23:8] != 16'd0) : (m_axis_tdata[7:0] == 8'd0)), "byte fields inconsistent with byte_valid")

  // Nothing is offered after reset has been sampled
  `B64SD_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the base64 stream decoder: random traffic, stalls, scoreboard.
module testbench;
  import b64sd_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned SettleLimit = 20000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned PhaseChars  = 190;
  // Register indexes with no register behind them
  localparam logic [1:0]  CfgIdxSpareLo = 2'd2;
  localparam logic [1:0]  CfgIdxSpareHi = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_char
  logic        s_axis_tlast  = 1'b0; // last_char
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [7:0] byte_out, [23:8] bytes_so_far
  logic        m_axis_tuser;         // byte_valid
  logic        m_axis_tlast;         // message_end

  base64_stream_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pending characters, expected results, bookkeeping
  char_item_t  char_queue[$];
  result_t     expected_results[$];
  logic [7:0]  msg_bytes[$];
  int unsigned chars_pushed  = 0;
  int unsigned fail_count    = 0;
  int unsigned cycle_count   = 0;
  int unsigned holds_asked   = 0;
  int unsigned holds_granted = 0;

  // Predicted decoder state and register copies
  logic [1:0]  quad_pos    = '0;
  logic [5:0]  held_sextet = '0;
  logic        pad_hit     = 1'b0;
  logic [15:0] bytes_given = '0;
  logic [15:0] limit_reg   = LimitReset;
  logic        paste_reg   = 1'b0;

  // {in alphabet, value}
  function automatic logic [6:0] char_sextet(input logic [7:0] ch);
    logic [7:0] t;
    logic [6:0] r;
    t = '0;
    r = '0;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      t = ch - ChUpA;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      t = ch - ChLoA + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      t = ch - ChDig0 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (ch == ChPlus) begin
      r = {1'b1, SextPlus};
    end else if (ch == ChSlash) begin
      r = {1'b1, SextSlash};
    end
    return r;
  endfunction

  // Encoder side: sextet value to alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 6'd26) return ChUpA + {2'b00, v};
    if (v < 6'd52) return ChLoA + {2'b00, v} - 8'd26;
    if (v < SextPlus) return ChDig0 + {2'b00, v} - 8'd52;
    if (v == SextPlus) return ChPlus;
    return ChSlash;
  endfunction

  function automatic logic [7:0] clip_safe(input logic [7:0] b);
    if (b == ChTab) return ChSpace;
    if (b == ChLf) return ChCr;
    if (b < ChSpace || b >= ChDel) return ChSpace;
    return b;
  endfunction

  // Advance the predicted state by one accepted character, queue its result
  function automatic void decode_char(input logic [7:0] ch, input logic last);
    logic [6:0] sx;
    logic [7:0] b;
    logic       got_byte;
    result_t    r;
    b = '0;
    got_byte = 1'b0;
    if (!pad_hit) begin
      if (ch == ChPad) begin
        pad_hit = 1'b1;
      end else begin
        sx = char_sextet(ch);
        if (sx[6]) begin
          case (quad_pos)
            2'd0: got_byte = 1'b0;
            2'd1: begin
              b = {held_sextet, sx[5:4]};
              got_byte = 1'b1;
            end
            2'd2: begin
              b = {held_sextet[3:0], sx[5:2]};
              got_byte = 1'b1;
            end
            default: begin
              b = {held_sextet[1:0], sx[5:0]};
              got_byte = 1'b1;
            end
          endcase
          held_sextet = sx[5:0];
          quad_pos = quad_pos + 2'd1;
        end
      end
    end
    // bytes past the limit are dropped
    if (got_byte) begin
      if (bytes_given < limit_reg) begin
        bytes_given = bytes_given + 16'd1;
        if (paste_reg) b = clip_safe(b);
      end else begin
        got_byte = 1'b0;
        b = '0;
      end
    end
    if (got_byte || last) begin
      r.byte_out     = b;
      r.byte_valid   = got_byte;
      r.message_end  = last;
      r.bytes_so_far = bytes_given;
      expected_results.push_back(r);
    end
    if (last) begin
      quad_pos    = '0;
      held_sextet = '0;
      pad_hit     = 1'b0;
      bytes_given = '0;
    end
  endfunction

  // Driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  char_item_t  next_char;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (char_queue.size() != 0) begin
        next_char = char_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_char.ch;
        s_axis_tlast  <= next_char.last;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern per window, plus requested long hold-offs
  int unsigned hold_left   = 0;
  int unsigned window_left = 0;
  int unsigned stall_mode  = 0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        window_left <= $urandom_range(16, 96);
      end else begin
        window_left <= window_left - 1;
      end
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (cycle_count % 3 == 0);
      endcase
    end
  end

  // Input monitor: predict on each accepted character transaction
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) decode_char(s_axis_tdata, s_axis_tlast);
  end

  // Output monitor: compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.byte_out     = m_axis_tdata[7:0];
      seen.bytes_so_far = m_axis_tdata[23:8];
      seen.byte_valid   = m_axis_tuser;
      seen.message_end  = m_axis_tlast;
      if (expected_results.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MaxReports)
          $display("unexpected result: byte=%02h valid=%0b end=%0b count=%0d",
                   seen.byte_out, seen.byte_valid, seen.message_end, seen.bytes_so_far);
      end else begin
        want = expected_results.pop_front();
        if (seen.byte_out != want.byte_out || seen.byte_valid != want.byte_valid ||
            seen.message_end != want.message_end ||
            seen.bytes_so_far != want.bytes_so_far) begin
          fail_count = fail_count + 1;
          if (fail_count <= MaxReports)
            $display("mismatch: exp byte=%02h valid=%0b end=%0b count=%0d, got byte=%02h valid=%0b end=%0b count=%0d",
                     want.byte_out, want.byte_valid, want.message_end, want.bytes_so_far,
                     seen.byte_out, seen.byte_valid, seen.message_end, seen.bytes_so_far);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** base64_stream_decoder: FAILED **");
      $finish;
    end
  end

  task automatic push_char(input logic [7:0] ch, input logic last);
    char_item_t it;
    it.ch = ch;
    it.last = last;
    char_queue.push_back(it);
    chars_pushed = chars_pushed + 1;
  endtask

  task automatic push_text(input string s, input bit end_msg);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i], end_msg && (i == s.len() - 1));
  endtask

  // Encode msg_bytes as one message; optional filler, truncation or stray pad
  task automatic push_message(input bit padded, input bit noisy, input bit broken);
    logic [7:0]  chars[$];
    logic [23:0] grp;
    logic [7:0]  junk;
    int          n;
    int          i;
    int          k;
    int          keep;
    n = msg_bytes.size();
    for (i = 0; i < n; i += 3) begin
      k = (n - i > 3) ? 3 : n - i;
      grp = {msg_bytes[i], (k > 1) ? msg_bytes[i+1] : 8'h00, (k > 2) ? msg_bytes[i+2] : 8'h00};
      chars.push_back(sextet_char(grp[23:18]));
      chars.push_back(sextet_char(grp[17:12]));
      if (k > 1) chars.push_back(sextet_char(grp[11:6]));
      if (k > 2) chars.push_back(sextet_char(grp[5:0]));
      if (padded && k < 3) chars.push_back(ChPad);
      if (padded && k == 1) chars.push_back(ChPad);
    end
    if (broken && chars.size() != 0) begin
      keep = $urandom_range(1, chars.size());
      while (chars.size() > keep) void'(chars.pop_back());
      if ($urandom_range(0, 1) != 0) chars[$urandom_range(0, keep - 1)] = ChPad;
    end
    if (chars.size() == 0) chars.push_back(ChPad);
    for (i = 0; i < chars.size(); i++) begin
      // whitespace or high bytes between characters, skipped by the decoder
      if (noisy && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 4))
          0: junk = ChLf;
          1: junk = ChCr;
          2: junk = ChSpace;
          3: junk = ChTab;
          default: junk = 8'($urandom_range(128, 255));
        endcase
        push_char(junk, 1'b0);
      end
      push_char(chars[i], i == chars.size() - 1);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgIdxLimit) limit_reg = val;
    else if (idx == CfgIdxPaste) paste_reg = val[0];
    @(negedge clk_i);
  endtask

  // Wait for all characters taken, all results back, and the pipeline empty
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    while (char_queue.size() != 0 || s_axis_tvalid) @(negedge clk_i);
    while (expected_results.size() != 0 && guard < SettleLimit) begin
      @(negedge clk_i);
      guard = guard + 1;
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    int          ph;
    int          i;
    int          n;
    int          kind;
    logic [15:0] lim;
    logic [15:0] pdat;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: pad ends a quad, extreme sextets with skipped 00/FF,
    // characters after the pad ignored, message with no bytes
    push_text("TWE=", 1'b1);
    push_char(8'h00, 1'b0);
    push_text("//", 1'b0);
    push_char(8'hff, 1'b0);
    push_text("//", 1'b1);
    push_text("QQ=QUJ", 1'b1);
    push_char(8'h80, 1'b1);
    wait_idle();

    // Paste mode on tab, LF, DEL, other control and high bytes; spare indexes ignored
    write_reg(CfgIdxLimit, 16'hffff);
    write_reg(CfgIdxPaste, 16'h0001);
    write_reg(CfgIdxSpareLo, 16'h0000);
    write_reg(CfgIdxSpareHi, 16'hffff);
    msg_bytes = '{ChTab, ChLf, ChDel, 8'h1f, 8'h41, 8'hff};
    push_message(1'b1, 1'b0, 1'b0);
    wait_idle();

    // Random phases, each under its own limit and paste setting
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: lim = 16'd0;
        1: lim = 16'd1;
        2: lim = 16'd3;
        3: lim = LimitReset;
        4: lim = 16'hffff;
        5: lim = 16'($urandom_range(0, 40));
        6: lim = 16'($urandom_range(0, 65535));
        default: lim = 16'($urandom_range(4, 12));
      endcase
      pdat = 16'($urandom_range(0, 65535));
      pdat[0] = ~ph[0];
      write_reg(CfgIdxLimit, lim);
      write_reg(CfgIdxPaste, pdat);

      chars_pushed = 0;
      while (chars_pushed < PhaseChars) begin
        kind = $urandom_range(0, 9);
        if (kind >= 8) begin
          // garbage: any byte values
          n = $urandom_range(1, 10);
          for (i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)), i == n - 1);
        end else begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
          msg_bytes.delete();
          for (i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(0, 255)));
          push_message($urandom_range(0, 3) != 0, kind == 6, kind == 7);
        end
      end
      // long receiver hold-off while the sender keeps offering
      if (ph == 1 || ph == 5) holds_asked = holds_asked + 1;
      wait_idle();
    end

    if (expected_results.size() != 0) begin
      fail_count = fail_count + expected_results.size();
      $display("%0d expected results never arrived", expected_results.size());
    end
    if (fail_count == 0) begin
      $display("** base64_stream_decoder: PASSED **");
    end else begin
      $display("** base64_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule
